@@ hw/rtl/mll_pkg.sv @@
// shared types and constants of the mipmap level locator
package mll_pkg;

  localparam int unsigned LVL_W   = 5;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned LEN_W   = 36;
  localparam int unsigned SZ_W    = 34;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned FMT_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned STEP_W  = 3;

  localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(128);

  // result status codes
  localparam logic [STAT_W-1:0] ST_FIT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_LENGTH = 2'd3;

  typedef enum logic [FMT_W-1:0] {
    FMT_DXT1     = 3'd0,
    FMT_DXT3     = 3'd1,
    FMT_DXT5     = 3'd2,
    FMT_ARGB1555 = 3'd3,
    FMT_ARGB4    = 3'd4,
    FMT_RGB565   = 3'd5,
    FMT_RGB8     = 3'd6,
    FMT_ARGB8    = 3'd7
  } fmt_t;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram step addresses
  localparam step_t STEP_LOAD  = 3'd0;
  localparam step_t STEP_HDR   = 3'd1;
  localparam step_t STEP_MUL   = 3'd2;
  localparam step_t STEP_SCALE = 3'd3;
  localparam step_t STEP_FIT   = 3'd4;
  localparam step_t STEP_EMIT  = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_HDR   = 3'd1,
    OP_MUL   = 3'd2,
    OP_SCALE = 3'd3,
    OP_FIT   = 3'd4,
    OP_EMIT  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_OUT  = 2'd2
  } hold_t;

  typedef enum logic [2:0] {
    COND_NEVER  = 3'd0,
    COND_ALWAYS = 3'd1,
    COND_SHORT  = 3'd2,
    COND_END    = 3'd3,
    COND_FIT    = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    cond_t cond;
    step_t target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic short_hdr;
    logic loop_end;
    logic fits;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/mll_if.sv @@
// channel interfaces of the mipmap level locator
interface mll_in_if;
  logic                       valid;
  logic                       ready;
  logic [mll_pkg::LVL_W-1:0]  requested_level;
  modport source (output valid, output requested_level, input ready);
  modport sink   (input valid, input requested_level, output ready);
endinterface

interface mll_out_if;
  logic                       valid;
  logic                       ready;
  logic [mll_pkg::LEN_W-1:0]  start_byte;
  logic [mll_pkg::SZ_W-1:0]   byte_count;
  logic [mll_pkg::LVL_W-1:0]  level_used;
  logic [mll_pkg::STAT_W-1:0] status;
  modport source (output valid, output start_byte, output byte_count, output level_used,
                  output status, input ready);
  modport sink   (input valid, input start_byte, input byte_count, input level_used,
                  input status, output ready);
endinterface

interface mll_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mll_pkg::CIDX_W-1:0] index;
  logic [mll_pkg::LEN_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/mll_seq.sv @@
// microprogram sequencer: step counter, control store and jump logic
module mll_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  mll_pkg::dp_stat_t stat,
  output mll_pkg::ctrl_t    ctrl
);

  mll_pkg::step_t  pc_r, pc_nxt;
  mll_pkg::uword_t uw;
  logic            go;
  logic            taken;

  // control store
  always_comb begin
    unique case (pc_r)
      mll_pkg::STEP_LOAD:
        uw = '{mll_pkg::OP_LOAD, mll_pkg::HOLD_IN, mll_pkg::COND_NEVER, mll_pkg::STEP_LOAD};
      mll_pkg::STEP_HDR:
        uw = '{mll_pkg::OP_HDR, mll_pkg::HOLD_NONE, mll_pkg::COND_SHORT, mll_pkg::STEP_EMIT};
      mll_pkg::STEP_MUL:
        uw = '{mll_pkg::OP_MUL, mll_pkg::HOLD_NONE, mll_pkg::COND_END, mll_pkg::STEP_EMIT};
      mll_pkg::STEP_SCALE:
        uw = '{mll_pkg::OP_SCALE, mll_pkg::HOLD_NONE, mll_pkg::COND_NEVER, mll_pkg::STEP_LOAD};
      mll_pkg::STEP_FIT:
        uw = '{mll_pkg::OP_FIT, mll_pkg::HOLD_NONE, mll_pkg::COND_FIT, mll_pkg::STEP_MUL};
      mll_pkg::STEP_EMIT:
        uw = '{mll_pkg::OP_EMIT, mll_pkg::HOLD_OUT, mll_pkg::COND_ALWAYS, mll_pkg::STEP_LOAD};
      default:
        uw = '{mll_pkg::OP_EMIT, mll_pkg::HOLD_NONE, mll_pkg::COND_ALWAYS, mll_pkg::STEP_LOAD};
    endcase
  end

  always_comb begin
    unique case (uw.hold)
      mll_pkg::HOLD_IN:  go = in_valid;
      mll_pkg::HOLD_OUT: go = stat.out_free;
      default:           go = 1'b1;
    endcase
    unique case (uw.cond)
      mll_pkg::COND_ALWAYS: taken = 1'b1;
      mll_pkg::COND_SHORT:  taken = stat.short_hdr;
      mll_pkg::COND_END:    taken = stat.loop_end;
      mll_pkg::COND_FIT:    taken = stat.fits;
      default:              taken = 1'b0;
    endcase
    if (!go) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + mll_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mll_pkg::STEP_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op = uw.op;
  assign ctrl.go = go;

  a_accept_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == mll_pkg::STEP_LOAD && in_valid) |=> pc_r == mll_pkg::STEP_HDR)
    else $error("accepted request did not start the header check");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= mll_pkg::STEP_EMIT)
    else $error("step counter left the program");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == mll_pkg::STEP_EMIT && !stat.out_free) |=> pc_r == mll_pkg::STEP_EMIT)
    else $error("result step left while output register was full");

endmodule

@@ hw/rtl/mll_dp.sv @@
// level walk datapath: size multiplier, offset accumulator, fit compare, output register
module mll_dp #(
  parameter int unsigned MAX_LEVELS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mll_pkg::ctrl_t              ctrl,
  output mll_pkg::dp_stat_t           stat,
  input  logic                        in_valid,
  input  logic [mll_pkg::LVL_W-1:0]   in_level,
  input  mll_pkg::fmt_t               cfg_fmt,
  input  logic [mll_pkg::DIM_W-1:0]   cfg_width,
  input  logic [mll_pkg::DIM_W-1:0]   cfg_height,
  input  logic [mll_pkg::LEN_W-1:0]   cfg_length,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mll_pkg::LEN_W-1:0]   out_start,
  output logic [mll_pkg::SZ_W-1:0]    out_count,
  output logic [mll_pkg::LVL_W-1:0]   out_level,
  output logic [mll_pkg::STAT_W-1:0]  out_status
);

  localparam int unsigned IDX_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned LVL_W = mll_pkg::LVL_W;
  localparam int unsigned DIM_W = mll_pkg::DIM_W;
  localparam int unsigned LEN_W = mll_pkg::LEN_W;
  localparam int unsigned SZ_W  = mll_pkg::SZ_W;
  localparam int unsigned PROD_W = mll_pkg::PROD_W;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_LEVELS - 1);

  logic [LVL_W-1:0]  req_r;
  logic [DIM_W-1:0]  w_r, h_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PROD_W-1:0] prod_r;
  logic [SZ_W-1:0]   sz_r;
  logic [LEN_W-1:0]  start_r;
  logic [LEN_W-1:0]  best_start_r;
  logic [SZ_W-1:0]   best_sz_r;
  logic [LVL_W-1:0]  best_lvl_r;
  logic              found_r;
  logic              short_r;
  logic              out_valid_r;
  logic [LEN_W-1:0]  out_start_r;
  logic [SZ_W-1:0]   out_count_r;
  logic [LVL_W-1:0]  out_level_r;
  logic [mll_pkg::STAT_W-1:0] out_status_r;

  logic [DIM_W-1:0]  wc, hc;
  logic [DIM_W:0]    mul_a, mul_b;
  logic [2*DIM_W+1:0] mul_p;
  logic              compressed;
  logic [SZ_W-1:0]   sz_nxt;
  logic [LEN_W:0]    end_sum;
  logic [LVL_W-1:0]  req_sat;
  logic              out_free;

  // level dims clamped to one
  assign wc = (w_r == '0) ? DIM_W'(1) : w_r;
  assign hc = (h_r == '0) ? DIM_W'(1) : h_r;
  assign compressed = (cfg_fmt == mll_pkg::FMT_DXT1) || (cfg_fmt == mll_pkg::FMT_DXT3) ||
                      (cfg_fmt == mll_pkg::FMT_DXT5);
  // block counts round up to 4x4 for the compressed formats
  assign mul_a = compressed ? ((DIM_W + 1)'(wc) + (DIM_W + 1)'(3)) >> 2 : (DIM_W + 1)'(wc);
  assign mul_b = compressed ? ((DIM_W + 1)'(hc) + (DIM_W + 1)'(3)) >> 2 : (DIM_W + 1)'(hc);
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (cfg_fmt)
      mll_pkg::FMT_DXT1:     sz_nxt = SZ_W'({prod_r, 3'b000});
      mll_pkg::FMT_DXT3,
      mll_pkg::FMT_DXT5:     sz_nxt = SZ_W'({prod_r, 4'b0000});
      mll_pkg::FMT_ARGB1555,
      mll_pkg::FMT_ARGB4,
      mll_pkg::FMT_RGB565:   sz_nxt = SZ_W'({prod_r, 1'b0});
      mll_pkg::FMT_RGB8:     sz_nxt = SZ_W'(prod_r) + SZ_W'({prod_r, 1'b0});
      mll_pkg::FMT_ARGB8:    sz_nxt = SZ_W'({prod_r, 2'b00});
      default:               sz_nxt = '0;
    endcase
  end

  assign end_sum  = (LEN_W + 1)'(start_r) + (LEN_W + 1)'(sz_r);
  assign req_sat  = (in_level > LVL_MAX) ? LVL_MAX : in_level;
  assign out_free = !out_valid_r || out_ready;

  assign stat.short_hdr = cfg_length < mll_pkg::HEADER_BYTES;
  assign stat.loop_end  = (idx_r > IDX_W'(req_r)) || (w_r == '0 && h_r == '0);
  assign stat.fits      = end_sum <= (LEN_W + 1)'(cfg_length);
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b1;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (ctrl.op)
        mll_pkg::OP_LOAD: begin
          if (in_valid) begin
            found_r <= 1'b1;
          end
        end
        mll_pkg::OP_HDR: short_r <= stat.short_hdr;
        mll_pkg::OP_FIT: begin
          if (!stat.fits && idx_r == '0) begin
            found_r <= 1'b0;
          end
        end
        mll_pkg::OP_EMIT: begin
          if (ctrl.go) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
      if (out_valid_r && out_ready && !(ctrl.op == mll_pkg::OP_EMIT)) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      mll_pkg::OP_LOAD: begin
        if (in_valid) begin
          req_r        <= req_sat;
          w_r          <= cfg_width;
          h_r          <= cfg_height;
          idx_r        <= '0;
          start_r      <= mll_pkg::HEADER_BYTES;
          best_start_r <= mll_pkg::HEADER_BYTES;
          best_sz_r    <= '0;
          best_lvl_r   <= '0;
        end
      end
      mll_pkg::OP_MUL: begin
        w_r    <= wc;
        h_r    <= hc;
        prod_r <= mul_p[PROD_W-1:0];
      end
      mll_pkg::OP_SCALE: sz_r <= sz_nxt;
      mll_pkg::OP_FIT: begin
        if (stat.fits) begin
          best_start_r <= start_r;
          best_sz_r    <= sz_r;
          best_lvl_r   <= idx_r[LVL_W-1:0];
          start_r      <= end_sum[LEN_W-1:0];
          w_r          <= w_r >> 1;
          h_r          <= h_r >> 1;
          idx_r        <= idx_r + IDX_W'(1);
        end
      end
      mll_pkg::OP_EMIT: begin
        if (ctrl.go) begin
          if (short_r) begin
            out_start_r  <= '0;
            out_count_r  <= '0;
            out_level_r  <= '0;
            out_status_r <= mll_pkg::ST_SHORT;
          end else begin
            out_start_r  <= best_start_r;
            out_count_r  <= best_sz_r;
            out_level_r  <= best_lvl_r;
            out_status_r <= found_r ? mll_pkg::ST_FIT : mll_pkg::ST_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_start  = out_start_r;
  assign out_count  = out_count_r;
  assign out_level  = out_level_r;
  assign out_status = out_status_r;

  a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == mll_pkg::ST_SHORT) |->
      (out_start_r == '0 && out_count_r == '0 && out_level_r == '0))
    else $error("short file result carries a range");

  a_range_in_file: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == mll_pkg::ST_FIT) |->
      ((LEN_W + 1)'(out_start_r) + (LEN_W + 1)'(out_count_r) <= (LEN_W + 1)'(cfg_length)))
    else $error("located level runs past the file end");

  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == mll_pkg::OP_FIT && stat.fits) |=> idx_r == $past(idx_r) + IDX_W'(1))
    else $error("level index did not advance after a fitting level");

endmodule

@@ hw/rtl/mipmap_level_locator.sv @@
// top level of the mipmap level locator: config registers, sequencer and datapath
//
//  channel  dir  signals                                          transaction
//  in_ch    in   valid ready requested_level                      one level request
//  out_ch   out  valid ready start_byte byte_count level_used status  one located range
//  cfg_ch   in   valid ready index data                           one register write
//
// a file shorter than the header goes from the header check straight to the result step;
// otherwise the walk stops after the requested level, at the end of the chain, or at the
// first level that runs past the file end
// the level loop runs on one shared 17x17 multiplier, one scaler and one 37-bit
// add and compare, stepped by the microprogram through its multiply, scale and fit steps
// reset (synchronous, rst_n low) zeroes the config registers, clears output valid
// and parks the sequencer at the request step
// a new request is taken while the previous result waits in the output register;
// the sequencer only stalls at its result step when that register is still full
module mipmap_level_locator #(
  parameter int unsigned MAX_LEVELS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mll_in_if.sink    in_ch,
  mll_out_if.source out_ch,
  mll_cfg_if.sink   cfg_ch
);

  mll_pkg::fmt_t                  fmt_r;
  logic [mll_pkg::DIM_W-1:0]      width_r;
  logic [mll_pkg::DIM_W-1:0]      height_r;
  logic [mll_pkg::LEN_W-1:0]      length_r;

  mll_pkg::ctrl_t    ctrl;
  mll_pkg::dp_stat_t stat;

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= mll_pkg::FMT_DXT1;
      width_r  <= '0;
      height_r <= '0;
      length_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mll_pkg::CFG_FORMAT: fmt_r    <= mll_pkg::fmt_t'(cfg_ch.data[mll_pkg::FMT_W-1:0]);
        mll_pkg::CFG_WIDTH:  width_r  <= cfg_ch.data[mll_pkg::DIM_W-1:0];
        mll_pkg::CFG_HEIGHT: height_r <= cfg_ch.data[mll_pkg::DIM_W-1:0];
        mll_pkg::CFG_LENGTH: length_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // request taken only at the program's first step
  assign in_ch.ready = (ctrl.op == mll_pkg::OP_LOAD);

  mll_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mll_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_valid   (in_ch.valid),
    .in_level   (in_ch.requested_level),
    .cfg_fmt    (fmt_r),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_length (length_r),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_start  (out_ch.start_byte),
    .out_count  (out_ch.byte_count),
    .out_level  (out_ch.level_used),
    .out_status (out_ch.status)
  );

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the mipmap level locator
module testbench;
  import mll_pkg::*;

  // level limit of the instance and of the level-walk predictor
  localparam int unsigned MAX_LEVELS = 32;
  // percent of cycles in which each side idles
  localparam int unsigned IDLE_PCT = 13;
  // length of the long output hold-off
  localparam int unsigned HOLD_CYCLES = 400;
  // run ceiling, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // random requests after the directed part
  localparam int unsigned RANDOM_REQUESTS = 1100;

  // one located byte range, as the result channel carries it
  typedef struct packed {
    logic [LEN_W-1:0]  start_byte;
    logic [SZ_W-1:0]   byte_count;
    logic [LVL_W-1:0]  level_used;
    logic [STAT_W-1:0] status;
  } range_t;

  logic clk;
  logic rst_n;

  mll_in_if  in_ch();
  mll_out_if out_ch();
  mll_cfg_if cfg_ch();

  mipmap_level_locator #(
    .MAX_LEVELS(MAX_LEVELS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // shadow copy of the configuration registers
  fmt_t             fmt_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic [LEN_W-1:0] length_q;

  // requests waiting for the driver, and ranges waiting for the monitor
  logic [LVL_W-1:0] request_q[$];
  range_t           range_q[$];

  int unsigned pushed;       // requests handed to the driver
  int unsigned accepted;     // request transactions taken by the block
  int unsigned bad_count;    // mismatches and unexpected results
  int unsigned cycle_count;
  int unsigned hold_cnt;
  bit          hold_req;     // asks the monitor for the long hold-off
  bit          hold_done;
  bit          steady;       // no idling on either side while set
  range_t      want_r;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bytes of one level of w x h pixels
  function automatic longint unsigned level_size(input fmt_t f, input longint unsigned w,
                                                 input longint unsigned h);
    longint unsigned bw;
    longint unsigned bh;
    bw = (w + 3) / 4;
    bh = (h + 3) / 4;
    case (f)
      FMT_DXT1:                           return bw * bh * 8;
      FMT_DXT3, FMT_DXT5:                 return bw * bh * 16;
      FMT_ARGB1555, FMT_ARGB4, FMT_RGB565: return w * h * 2;
      FMT_RGB8:                           return w * h * 3;
      default:                            return w * h * 4;
    endcase
  endfunction

  // walk levels 0..lvl of the chain; stops early once both sides reach zero
  function automatic void walk_chain(input fmt_t f, input logic [DIM_W-1:0] bw,
                                     input logic [DIM_W-1:0] bh, input int unsigned lvl,
                                     output longint unsigned off, output longint unsigned sz,
                                     output logic [LVL_W-1:0] last);
    longint unsigned w;
    longint unsigned h;
    int unsigned     i;
    w    = bw;
    h    = bh;
    off  = 0;
    sz   = 0;
    last = '0;
    for (i = 0; i <= lvl && i < MAX_LEVELS && (w != 0 || h != 0); i++) begin
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      off += sz;
      sz   = level_size(f, w, h);
      last = LVL_W'(i);
      w    = w >> 1;
      h    = h >> 1;
    end
  endfunction

  // expected range for one request under the shadow configuration
  function automatic range_t locate_level(input logic [LVL_W-1:0] req);
    range_t            r;
    longint unsigned   off;
    longint unsigned   sz;
    longint unsigned   start;
    logic [LVL_W-1:0]  last;
    int                lvl;
    int                top;
    top = (req > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : req;
    // file too short to even hold the header
    if (length_q < HEADER_BYTES) begin
      r.start_byte = '0;
      r.byte_count = '0;
      r.level_used = '0;
      r.status     = ST_SHORT;
      return r;
    end
    // fall back one level at a time until the range fits in the file
    for (lvl = top; lvl >= 0; lvl--) begin
      walk_chain(fmt_q, width_q, height_q, lvl, off, sz, last);
      start = HEADER_BYTES + off;
      if (start + sz <= length_q) begin
        r.start_byte = LEN_W'(start);
        r.byte_count = SZ_W'(sz);
        r.level_used = last;
        r.status     = ST_FIT;
        return r;
      end
    end
    // nothing fits: empty range right after the header
    r.start_byte = HEADER_BYTES;
    r.byte_count = '0;
    r.level_used = '0;
    r.status     = ST_NONE;
    return r;
  endfunction

  // request driver: offers queued requests, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        range_q.push_back(locate_level(in_ch.requested_level));
        accepted++;
      end
      // a request still on offer stays put until taken
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid           <= 1'b1;
          in_ch.requested_level <= request_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off length, counted apart from the monitor
  always @(posedge clk) begin
    if (rst_n && hold_req && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end
  end

  // result monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (range_q.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected result: start %0d count %0d level %0d status %0d",
                     out_ch.start_byte, out_ch.byte_count, out_ch.level_used, out_ch.status);
          bad_count++;
        end else begin
          want_r = range_q.pop_front();
          if (out_ch.start_byte !== want_r.start_byte || out_ch.byte_count !== want_r.byte_count
              || out_ch.level_used !== want_r.level_used || out_ch.status !== want_r.status) begin
            if (bad_count < 10) begin
              $display("mismatch: expected start %0d count %0d level %0d status %0d",
                       want_r.start_byte, want_r.byte_count, want_r.level_used, want_r.status);
              $display("          actual   start %0d count %0d level %0d status %0d",
                       out_ch.start_byte, out_ch.byte_count, out_ch.level_used, out_ch.status);
            end
            bad_count++;
          end
        end
      end
      // long hold-off so the output register fills and the input backs up
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // run ceiling
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // queue one request for the driver
  task automatic push_request(input logic [LVL_W-1:0] req);
    request_q.push_back(req);
    pushed++;
  endtask

  // wait until every queued request is taken and every result has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (!rst_n || accepted != pushed || range_q.size() != 0);
  endtask

  // one register write transaction; valid stays high for a following write
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    case (idx)
      CFG_FORMAT: fmt_q    = fmt_t'(val[FMT_W-1:0]);
      CFG_WIDTH:  width_q  = val[DIM_W-1:0];
      CFG_HEIGHT: height_q = val[DIM_W-1:0];
      CFG_LENGTH: length_q = val;
      default: ;
    endcase
  endtask

  // rewrite all registers once the block has drained; unused upper data bits
  // sometimes carry junk that the block must drop
  task automatic set_registers(input fmt_t f, input logic [DIM_W-1:0] w,
                               input logic [DIM_W-1:0] h, input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] junk;
    wait_idle();
    junk = ($urandom_range(3) == 0) ? LEN_W'({$urandom, $urandom}) : '0;
    write_reg(CFG_FORMAT, {junk[LEN_W-1:FMT_W], f});
    write_reg(CFG_WIDTH,  {junk[LEN_W-1:DIM_W], w});
    write_reg(CFG_HEIGHT, {junk[LEN_W-1:DIM_W], h});
    write_reg(CFG_LENGTH, len);
    cfg_ch.valid <= 1'b0;
  endtask

  // stimulus: directed corner cases, then random configuration phases
  initial begin
    fmt_t             f;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [LEN_W-1:0] len;
    logic [LVL_W-1:0] last;
    logic [LVL_W-1:0] top;
    longint unsigned  off;
    longint unsigned  sz;
    longint unsigned  total;
    int unsigned      k;
    int unsigned      n;
    int unsigned      sel;
    int unsigned      p;
    int unsigned      rand_items;
    int unsigned      steady_phase;
    int unsigned      hold_phase;

    // every block input known from time zero
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.requested_level = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_FORMAT;
    cfg_ch.data           = '0;
    fmt_q     = FMT_DXT1;
    width_q   = '0;
    height_q  = '0;
    length_q  = '0;
    pushed    = 0;
    accepted  = 0;
    bad_count = 0;
    hold_cnt  = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    steady    = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero file length, so the header check trips
    push_request(LVL_W'(0));
    push_request(LVL_W'(31));

    // full 64k DXT1 chain in a huge file; requests past the chain end
    set_registers(FMT_DXT1, '1, '1, '1);
    push_request(LVL_W'(0));
    push_request(LVL_W'(16));
    push_request(LVL_W'(31));

    // ARGB8 level 0 one byte too big, so nothing fits at all
    walk_chain(FMT_ARGB8, '1, '1, 0, off, sz, last);
    set_registers(FMT_ARGB8, '1, '1, LEN_W'(HEADER_BYTES + sz - 1));
    push_request(LVL_W'(0));
    push_request(LVL_W'(31));

    // level 0 fits with not a byte to spare
    set_registers(FMT_ARGB8, '1, '1, LEN_W'(HEADER_BYTES + sz));
    push_request(LVL_W'(2));

    // zero base size with a header-only file
    set_registers(FMT_RGB8, '0, '0, HEADER_BYTES);
    push_request(LVL_W'(7));

    // one byte short of the header
    set_registers(FMT_RGB8, '0, DIM_W'(9), HEADER_BYTES - 1);
    push_request(LVL_W'(0));

    // zero width only, clamped to one pixel
    set_registers(FMT_RGB565, '0, DIM_W'(9), '1);
    push_request(LVL_W'(31));

    // every pixel format on an odd size
    for (k = 0; k < 8; k++) begin
      set_registers(fmt_t'(k), DIM_W'(37), DIM_W'(5), '1);
      push_request(LVL_W'($urandom_range(31)));
    end

    // random phases: mostly small textures, some lengths near level boundaries
    steady_phase = $urandom_range(2, 10);
    hold_phase   = $urandom_range(12, 20);
    rand_items   = 0;
    p            = 0;
    while (rand_items < RANDOM_REQUESTS) begin
      f   = fmt_t'($urandom_range(7));
      sel = $urandom_range(99);
      if (sel < 80) begin
        w = DIM_W'($urandom_range(64));
        h = DIM_W'($urandom_range(64));
      end else if (sel < 95) begin
        w = DIM_W'($urandom_range(2047));
        h = DIM_W'($urandom_range(2047));
      end else begin
        w = DIM_W'($urandom_range(65535));
        h = DIM_W'($urandom_range(65535));
      end
      if ($urandom_range(9) == 0) w = '0;
      if ($urandom_range(9) == 0) h = '0;

      // size of the whole chain, and its last level
      walk_chain(f, w, h, MAX_LEVELS - 1, off, sz, top);
      total = off + sz;
      case ($urandom_range(9))
        0: len = LEN_W'($urandom_range(127));
        1, 2, 3: begin
          // right at, or one byte either side of, the end of some level
          walk_chain(f, w, h, $urandom_range(top), off, sz, last);
          len = LEN_W'(HEADER_BYTES + off + sz + $urandom_range(2) - 1);
        end
        4: len = LEN_W'({$urandom, $urandom});
        5: len = '1;
        default: len = LEN_W'(HEADER_BYTES + ((total + 1) * $urandom_range(1000)) / 1000);
      endcase

      set_registers(f, w, h, len);
      steady = (p == steady_phase);
      if (p == hold_phase) hold_req = 1'b1;
      n = (p == hold_phase) ? 50 : (p == steady_phase) ? 80 : $urandom_range(8, 40);
      repeat (n) begin
        if ($urandom_range(9) < 7) push_request(LVL_W'($urandom_range(31)));
        else push_request(LVL_W'($urandom_range(top)));
      end
      rand_items += n;
      p++;
    end

    // drain, then give stray results a chance to show up
    wait_idle();
    repeat (64) @(posedge clk);
    if (bad_count == 0 && range_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
